### src/dms_pkg.sv
// ----------------------------------------------------------------------------
// dms_pkg
// Shared widths, codes and controller/datapath bundles for the device mode
// supervisor.
// ----------------------------------------------------------------------------
package dms_pkg;

    // Field widths
    localparam int OP_W    = 2;
    localparam int SECS_W  = 16;
    localparam int MODE_W  = 3;
    localparam int TAKEN_W = 17;
    localparam int TIMER_W = 32;
    localparam int WAIT_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADVANCE   = 2'd0;
    localparam logic [OP_W-1:0] OP_HEARTBEAT = 2'd1;
    localparam logic [OP_W-1:0] OP_FORCE     = 2'd2;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_DISABLED = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STOPPED  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STARTING = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STARTED  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOPPING = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STOPPED_WAIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STARTING_WAIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOPPING_WAIT   = 2'd3;

    // Configuration reset values
    localparam logic [WAIT_W-1:0] STOPPED_WAIT_RST    = 16'd60;
    localparam logic [WAIT_W-1:0] STARTING_WAIT_RST   = 16'd120;
    localparam logic [WAIT_W-1:0] HEARTBEAT_LIMIT_RST = 16'd300;
    localparam logic [WAIT_W-1:0] STOPPING_WAIT_RST   = 16'd120;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture a new item
        logic exec;     // apply one step of the item
        logic publish;  // copy the step result into the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;     // the pending step finishes the item
    } dp_status_t;

endpackage

### src/dms_cmd_if.sv
// ----------------------------------------------------------------------------
// dms_cmd_if
// Input item channel: operation, elapsed seconds and forced mode.
// ----------------------------------------------------------------------------
interface dms_cmd_if;
    import dms_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SECS_W-1:0] elapsed_seconds;
    logic [MODE_W-1:0] forced_mode;

    modport source (output valid, output operation, output elapsed_seconds,
                    output forced_mode, input ready);
    modport sink   (input valid, input operation, input elapsed_seconds,
                    input forced_mode, output ready);
endinterface

### src/dms_rsp_if.sv
// ----------------------------------------------------------------------------
// dms_rsp_if
// Result item channel: mode, transition count and both timers.
// ----------------------------------------------------------------------------
interface dms_rsp_if;
    import dms_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  current_mode;
    logic [TAKEN_W-1:0] transitions_taken;
    logic [TIMER_W-1:0] time_in_mode;
    logic [TIMER_W-1:0] heartbeat_age;

    modport source (output valid, output current_mode, output transitions_taken,
                    output time_in_mode, output heartbeat_age, input ready);
    modport sink   (input valid, input current_mode, input transitions_taken,
                    input time_in_mode, input heartbeat_age, output ready);
endinterface

### src/dms_cfg_if.sv
// ----------------------------------------------------------------------------
// dms_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dms_cfg_if;
    import dms_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WAIT_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/device_mode_supervisor_unit.sv
// ----------------------------------------------------------------------------
// device_mode_supervisor_unit
// Five-mode device supervisor with mode and heartbeat timers.
// ----------------------------------------------------------------------------
// One item is worked at a time. It is taken and then executed one step per
// cycle by a single compare-and-subtract step unit: heartbeat, force and zero
// or disabled-mode advances take one step, and an advance that crosses k
// timeouts takes k or k+1 steps, since the step unit settles one timeout per
// step. The next item is taken the cycle after the result is loaded into the
// output register, while that result may still wait to be taken; a final step
// is held only while an earlier result still occupies the output. Limit
// registers are written through the cfg channel, which is always ready.
module device_mode_supervisor_unit (
    input  logic clk,
    input  logic rst_n,
    dms_cfg_if.sink   cfg,
    dms_cmd_if.sink   cmd,
    dms_rsp_if.source rsp
);
    import dms_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic       in_ready;
    logic       out_valid;

    // Configuration writes land immediately
    assign cfg.ready = 1'b1;
    assign cmd.ready = in_ready;
    assign rsp.valid = out_valid;

    dms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    dms_datapath u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (dp_cmd),
        .status                (dp_status),
        .cfg_we                (cfg.valid),
        .cfg_index             (cfg.index),
        .cfg_data              (cfg.data),
        .in_operation          (cmd.operation),
        .in_elapsed_seconds    (cmd.elapsed_seconds),
        .in_forced_mode        (cmd.forced_mode),
        .out_current_mode      (rsp.current_mode),
        .out_transitions_taken (rsp.transitions_taken),
        .out_time_in_mode      (rsp.time_in_mode),
        .out_heartbeat_age     (rsp.heartbeat_age)
    );

endmodule

### src/dms_ctrl.sv
// ----------------------------------------------------------------------------
// dms_ctrl
// Sequencer: takes an item, steps the datapath until the item is done and
// hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module dms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  dms_pkg::dp_status_t status,
    output dms_pkg::dp_cmd_t    cmd
);
    import dms_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Decode commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold the final step until the output register is free
                cmd.exec    = !status.last || slot_free;
                cmd.publish = status.last && slot_free;
                if (cmd.publish)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_enters_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_EXEC)
        else $error("accepted item did not start execution");

    a_final_step_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && status.last && out_valid_reg && !out_ready)
        |=> (state_reg == S_EXEC && out_valid_reg))
        else $error("final step went ahead while the output was occupied");

    a_publish_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid_reg)
        else $error("published result not presented");

endmodule

### src/dms_datapath.sv
// ----------------------------------------------------------------------------
// dms_datapath
// Mode and timer state, limit registers and the step unit, which makes at most
// one transition per step, plus the result register.
// ----------------------------------------------------------------------------
module dms_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dms_pkg::dp_cmd_t               cmd,
    output dms_pkg::dp_status_t            status,
    // configuration write
    input  logic                           cfg_we,
    input  logic [dms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dms_pkg::WAIT_W-1:0]     cfg_data,
    // item fields
    input  logic [dms_pkg::OP_W-1:0]       in_operation,
    input  logic [dms_pkg::SECS_W-1:0]     in_elapsed_seconds,
    input  logic [dms_pkg::MODE_W-1:0]     in_forced_mode,
    // result fields
    output logic [dms_pkg::MODE_W-1:0]     out_current_mode,
    output logic [dms_pkg::TAKEN_W-1:0]    out_transitions_taken,
    output logic [dms_pkg::TIMER_W-1:0]    out_time_in_mode,
    output logic [dms_pkg::TIMER_W-1:0]    out_heartbeat_age
);
    import dms_pkg::*;

    // limit registers
    logic [WAIT_W-1:0]  stopped_wait_reg, starting_wait_reg;
    logic [WAIT_W-1:0]  heartbeat_limit_reg, stopping_wait_reg;

    // supervisor state
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [TIMER_W-1:0] mode_timer_reg, mode_timer_next;
    logic [TIMER_W-1:0] hb_timer_reg, hb_timer_next;

    // item in progress
    logic [OP_W-1:0]    op_reg;
    logic [SECS_W-1:0]  secs_reg, secs_next;
    logic [MODE_W-1:0]  fm_reg;
    logic [TAKEN_W-1:0] taken_reg, taken_next;

    // result register
    logic [MODE_W-1:0]  out_mode_reg;
    logic [TAKEN_W-1:0] out_taken_reg;
    logic [TIMER_W-1:0] out_mt_reg, out_hb_reg;

    // step signals
    logic [WAIT_W-1:0]  limit, limit_eff, need;
    logic [TIMER_W-1:0] timer;
    logic [MODE_W-1:0]  timeout_mode;
    logic               timed;
    logic [TIMER_W:0]   mt_sum, hb_sum;
    logic [TIMER_W-1:0] mt_sat, hb_sat;
    logic               last;

    // Select the limit and timer that apply in the current mode
    always_comb
    begin
        limit        = '0;
        timer        = mode_timer_reg;
        timeout_mode = MODE_DISABLED;
        timed        = 1'b1;
        case (mode_reg)
            MODE_STOPPED:
            begin
                limit        = stopped_wait_reg;
                timeout_mode = MODE_STARTING;
            end
            MODE_STARTING:
            begin
                limit        = starting_wait_reg;
                timeout_mode = MODE_STARTED;
            end
            MODE_STARTED:
            begin
                limit        = heartbeat_limit_reg;
                timer        = hb_timer_reg;
                timeout_mode = MODE_STOPPING;
            end
            MODE_STOPPING:
            begin
                limit        = stopping_wait_reg;
                timeout_mode = MODE_STOPPED;
            end
            default:
            begin
                timed = 1'b0;
            end
        endcase
        // a zero limit behaves as one second
        limit_eff = (limit == '0) ? {{(WAIT_W-1){1'b0}}, 1'b1} : limit;
        // seconds still outstanding; none once the timer is at or past the limit
        if (timer >= {{(TIMER_W-WAIT_W){1'b0}}, limit_eff})
        begin
            need = '0;
        end
        else
        begin
            need = limit_eff - timer[WAIT_W-1:0];
        end
    end

    // Saturating timer advance by the remaining seconds
    assign mt_sum = {1'b0, mode_timer_reg} + {{(TIMER_W-SECS_W+1){1'b0}}, secs_reg};
    assign hb_sum = {1'b0, hb_timer_reg} + {{(TIMER_W-SECS_W+1){1'b0}}, secs_reg};
    assign mt_sat = mt_sum[TIMER_W] ? '1 : mt_sum[TIMER_W-1:0];
    assign hb_sat = hb_sum[TIMER_W] ? '1 : hb_sum[TIMER_W-1:0];

    // One step of the item: at most one transition
    always_comb
    begin
        mode_next       = mode_reg;
        mode_timer_next = mode_timer_reg;
        hb_timer_next   = hb_timer_reg;
        secs_next       = secs_reg;
        taken_next      = taken_reg;
        last            = 1'b1;
        case (op_reg)
            OP_ADVANCE:
            begin
                if (secs_reg != '0)
                begin
                    if (!timed)
                    begin
                        mode_timer_next = mt_sat;
                        hb_timer_next   = hb_sat;
                        secs_next       = '0;
                    end
                    else if (secs_reg >= need)
                    begin
                        mode_next       = timeout_mode;
                        mode_timer_next = '0;
                        hb_timer_next   = '0;
                        secs_next       = secs_reg - need;
                        taken_next      = taken_reg + {{(TAKEN_W-1){1'b0}}, 1'b1};
                        last            = (secs_reg == need);
                    end
                    else
                    begin
                        mode_timer_next = mt_sat;
                        hb_timer_next   = hb_sat;
                        secs_next       = '0;
                    end
                end
            end
            OP_HEARTBEAT:
            begin
                hb_timer_next = '0;
            end
            OP_FORCE:
            begin
                // unknown mode codes leave the state alone
                if (fm_reg <= MODE_STOPPING)
                begin
                    mode_next       = fm_reg;
                    mode_timer_next = '0;
                    hb_timer_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status.last = last;

    // Limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_wait_reg    <= STOPPED_WAIT_RST;
            starting_wait_reg   <= STARTING_WAIT_RST;
            heartbeat_limit_reg <= HEARTBEAT_LIMIT_RST;
            stopping_wait_reg   <= STOPPING_WAIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STOPPED_WAIT:    stopped_wait_reg    <= cfg_data;
                REG_STARTING_WAIT:   starting_wait_reg   <= cfg_data;
                REG_HEARTBEAT_LIMIT: heartbeat_limit_reg <= cfg_data;
                REG_STOPPING_WAIT:   stopping_wait_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Supervisor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_DISABLED;
            mode_timer_reg <= '0;
            hb_timer_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            mode_reg       <= mode_next;
            mode_timer_reg <= mode_timer_next;
            hb_timer_reg   <= hb_timer_next;
        end
    end

    // Item in progress
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_operation;
            secs_reg  <= in_elapsed_seconds;
            fm_reg    <= in_forced_mode;
            taken_reg <= '0;
        end
        else if (cmd.exec)
        begin
            secs_reg  <= secs_next;
            taken_reg <= taken_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_mode_reg  <= mode_next;
            out_taken_reg <= taken_next;
            out_mt_reg    <= mode_timer_next;
            out_hb_reg    <= hb_timer_next;
        end
    end

    assign out_current_mode      = out_mode_reg;
    assign out_transitions_taken = out_taken_reg;
    assign out_time_in_mode      = out_mt_reg;
    assign out_heartbeat_age     = out_hb_reg;

    a_one_transition_per_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (taken_reg == $past(taken_reg))
                     || (taken_reg == $past(taken_reg) + {{(TAKEN_W-1){1'b0}}, 1'b1}))
        else $error("more than one transition in a step");

    a_mode_change_clears_timers: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != $past(mode_reg)) |-> (mode_timer_reg == '0 && hb_timer_reg == '0))
        else $error("mode changed without clearing the timers");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> (out_mode_reg == mode_reg && out_mt_reg == mode_timer_reg
                         && out_hb_reg == hb_timer_reg && out_taken_reg == taken_reg))
        else $error("published result differs from the state");

endmodule
